[hw/rtl/smh_pkg.sv]
package smh_pkg;

    localparam int unsigned PIX_W  = 16;
    localparam int unsigned CTR_W  = 17;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned KEY_W  = 64;
    localparam int unsigned NCH    = 4;

    typedef enum logic [1:0] {
        REQ_SAMPLE = 2'd0,
        REQ_READ   = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_NEW     = 3'd0,
        ST_COUNTED = 3'd1,
        ST_NULL    = 3'd2,
        ST_FULL    = 3'd3,
        ST_READ    = 3'd4,
        ST_CLEARED = 3'd5
    } t_status;

    localparam logic [2:0] CFG_NULL = 3'd4;

    // One classified request as it travels from the front part to the back part.
    typedef struct packed {
        t_req        req;
        logic        null_hit;
        logic [KEY_W-1:0] key;
        logic [9:0]  index;
    } t_cmd;

endpackage

[hw/rtl/smh_front.sv]
// Takes requests, checks for the null pixel and divides each channel by its bin size
// with a restoring divider, one quotient bit per cycle for all channels in parallel.
module smh_front import smh_pkg::*; #(
    parameter int unsigned CHANNELS = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_req_type,
    input  logic [NCH*PIX_W-1:0] i_pixels,
    input  logic [9:0]           i_entry_index,
    input  logic [NCH*PIX_W-1:0] i_bins,
    input  logic [PIX_W-1:0]     i_null_value,
    input  logic                 i_q_full,
    output logic                 o_busy,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_PUSH = 3'b100
    } t_state;

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [3:0]           r_step, n_step;
    logic [PIX_W-1:0]     r_quo [NCH];
    logic [PIX_W-1:0]     n_quo [NCH];
    logic [PIX_W:0]       r_rem [NCH];
    logic [PIX_W:0]       n_rem [NCH];
    logic [PIX_W-1:0]     r_dvd [NCH];
    logic [PIX_W-1:0]     n_dvd [NCH];

    assign o_busy = (r_state != S_IDLE);
    assign o_push = (r_state == S_PUSH) && !i_q_full;
    assign o_cmd  = r_cmd;

    always_comb begin
        logic [PIX_W-1:0] bin;
        logic [PIX_W:0]   t;
        n_state = r_state;
        n_cmd   = r_cmd;
        n_step  = r_step;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvd   = r_dvd;
        case (r_state)
            S_IDLE: begin
                if (i_start && (i_req_type != REQ_NONE)) begin
                    n_cmd.req      = t_req'(i_req_type);
                    n_cmd.index    = i_entry_index;
                    n_cmd.null_hit = 1'b0;
                    n_cmd.key      = '0;
                    for (int c = 0; c < NCH; c++) begin
                        n_dvd[c] = i_pixels[c*PIX_W +: PIX_W];
                        n_rem[c] = '0;
                        n_quo[c] = '0;
                        if (c < CHANNELS && i_pixels[c*PIX_W +: PIX_W] == i_null_value)
                            n_cmd.null_hit = 1'b1;
                    end
                    n_step  = '0;
                    n_state = (t_req'(i_req_type) == REQ_SAMPLE) ? S_DIV : S_PUSH;
                end
            end
            S_DIV: begin
                for (int c = 0; c < NCH; c++) begin
                    bin = i_bins[c*PIX_W +: PIX_W];
                    if (bin == '0) bin = PIX_W'(1);
                    t = {r_rem[c][PIX_W-1:0], r_dvd[c][PIX_W-1]};
                    n_dvd[c] = {r_dvd[c][PIX_W-2:0], 1'b0};
                    if (t >= {1'b0, bin}) begin
                        n_rem[c] = t - {1'b0, bin};
                        n_quo[c] = {r_quo[c][PIX_W-2:0], 1'b1};
                    end else begin
                        n_rem[c] = t;
                        n_quo[c] = {r_quo[c][PIX_W-2:0], 1'b0};
                    end
                end
                n_step = r_step + 4'd1;
                if (r_step == 4'd15) begin
                    for (int c = 0; c < NCH; c++)
                        n_cmd.key[c*PIX_W +: PIX_W] = (c < CHANNELS) ? n_quo[c] : '0;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_q_full) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cmd  <= n_cmd;
        r_step <= n_step;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
    end

endmodule

[hw/rtl/smh_queue.sv]
// Two-entry command queue between the front and back parts.
module smh_queue import smh_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

endmodule

[hw/rtl/smh_back.sv]
// Carries out commands: scans the key table one entry per cycle, updates counts,
// and forms the bin centers with one multiplier per channel.
module smh_back import smh_pkg::*; #(
    parameter int unsigned CHANNELS    = 2,
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_empty,
    input  t_cmd                 i_cmd,
    input  logic [NCH*PIX_W-1:0] i_bins,
    output logic                 o_pop,
    output logic                 o_valid,
    output logic [2:0]           o_status,
    output logic [NCH*CTR_W-1:0] o_centers,
    output logic [CNT_W-1:0]     o_bin_count,
    output logic                 o_entry_valid,
    output logic [10:0]          o_used_entries
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned FW = AW + 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_CHECK = 6'b000100,
        S_UPD   = 6'b001000,
        S_MUL   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    logic [KEY_W-1:0] r_keys [TABLE_DEPTH];
    logic [CNT_W-1:0] r_cnts [TABLE_DEPTH];

    t_state           r_state;
    t_cmd             r_cmd;
    logic [FW-1:0]    r_fill;
    logic [FW-1:0]    r_ptr;
    logic [AW-1:0]    r_rd_addr;
    logic             r_rd_ok;
    logic             r_iss;
    logic             r_dat_ok;
    logic [AW-1:0]    r_dat_addr;
    logic [KEY_W-1:0] r_rd_key;
    logic [CNT_W-1:0] r_rd_cnt;
    logic [KEY_W-1:0] r_ckey;
    logic [2:0]       r_status;
    logic [CNT_W-1:0] r_count;
    logic             r_evalid;
    logic [NCH*CTR_W-1:0] r_centers;
    logic             r_valid;

    logic [CNT_W-1:0] inc_cnt;

    assign o_pop          = (r_state == S_IDLE) && !i_empty;
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_centers      = r_centers;
    assign o_bin_count    = r_count;
    assign o_entry_valid  = r_evalid;
    assign o_used_entries = 11'(r_fill);
    assign inc_cnt = (r_rd_cnt == '1) ? r_rd_cnt : r_rd_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        r_rd_key   <= r_keys[r_rd_addr];
        r_rd_cnt   <= r_cnts[r_rd_addr];
        r_dat_addr <= r_rd_addr;
        if (r_state == S_UPD) begin
            if (r_status == ST_COUNTED) r_cnts[r_rd_addr] <= inc_cnt;
            else if (r_status == ST_NEW) begin
                r_keys[r_fill[AW-1:0]] <= r_cmd.key;
                r_cnts[r_fill[AW-1:0]] <= CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_valid  <= 1'b0;
            r_iss    <= 1'b0;
            r_dat_ok <= 1'b0;
        end else begin
            r_valid  <= (r_state == S_OUT);
            r_dat_ok <= r_iss;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_cmd     <= i_cmd;
                        r_count   <= '0;
                        r_evalid  <= 1'b0;
                        r_ckey    <= i_cmd.key;
                        r_ptr     <= '0;
                        r_iss     <= 1'b0;
                        r_rd_addr <= (i_cmd.req == REQ_READ) ? i_cmd.index[AW-1:0] : '0;
                        r_rd_ok   <= (i_cmd.req == REQ_READ)
                                     && (FW'(i_cmd.index) < r_fill)
                                     && (32'(i_cmd.index) < TABLE_DEPTH);
                        case (i_cmd.req)
                            REQ_CLEAR: begin
                                r_fill   <= '0;
                                r_status <= ST_CLEARED;
                                r_state  <= S_MUL;
                            end
                            REQ_READ: begin
                                r_status <= ST_READ;
                                r_state  <= S_CHECK;
                            end
                            default: begin
                                if (i_cmd.null_hit) begin
                                    r_status <= ST_NULL;
                                    r_state  <= S_MUL;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                        endcase
                    end
                end
                // One address is issued per cycle; its key comes back through the registered
                // read into r_rd_key, tagged by r_dat_ok and r_dat_addr.
                S_SCAN: begin
                    if (r_dat_ok && r_rd_key == r_cmd.key) begin
                        r_status  <= ST_COUNTED;
                        r_rd_addr <= r_dat_addr;
                        r_iss     <= 1'b0;
                        r_state   <= S_CHECK;
                    end else if (r_ptr < r_fill) begin
                        r_rd_addr <= r_ptr[AW-1:0];
                        r_ptr     <= r_ptr + 1'b1;
                        r_iss     <= 1'b1;
                    end else if (r_iss) begin
                        r_iss <= 1'b0;
                    end else begin
                        r_status <= (r_fill < FW'(TABLE_DEPTH)) ? ST_NEW : ST_FULL;
                        r_state  <= S_UPD;
                    end
                end
                S_CHECK: begin
                    // Lets the registered read of r_rd_addr land before S_UPD.
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (r_status == ST_COUNTED) begin
                        r_count  <= inc_cnt;
                        r_evalid <= 1'b1;
                    end else if (r_status == ST_NEW) begin
                        r_count  <= CNT_W'(1);
                        r_evalid <= 1'b1;
                        r_fill   <= r_fill + 1'b1;
                    end else if (r_status == ST_READ && r_rd_ok) begin
                        r_ckey   <= r_rd_key;
                        r_count  <= r_rd_cnt;
                        r_evalid <= 1'b1;
                    end
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    for (int c = 0; c < NCH; c++) begin
                        logic [PIX_W-1:0] b;
                        logic [2*PIX_W-1:0] p;
                        b = i_bins[c*PIX_W +: PIX_W];
                        if (b == '0) b = PIX_W'(1);
                        p = r_ckey[c*PIX_W +: PIX_W] * b + 32'(b >> 1);
                        // Centers are shown for a touched entry and for a dropped tuple.
                        r_centers[c*CTR_W +: CTR_W] <=
                            (c < CHANNELS && (r_evalid || r_status == ST_FULL))
                            ? p[CTR_W-1:0] : '0;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[hw/rtl/sparse_multichannel_histogram.sv]
// Sparse multichannel histogram. A request is taken when i_start is high and busy
// is low; its result appears on the o_ ports for one cycle with o_done, and the
// receiver cannot hold it off. The front end keeps busy high on a sample through
// its 16 divider steps and the hand-off to the queue, and on a read or clear through
// the hand-off alone, longer only while the queue is full. The back end then scans
// the key table one entry per cycle; a null pixel skips the scan. A short queue lets
// the divider work on the next sample while the table is scanned.
module sparse_multichannel_histogram import smh_pkg::*; #(
    parameter int unsigned CHANNELS    = 2,
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              busy,
    input  logic [1:0]        i_req_type,
    input  logic [PIX_W-1:0]  i_pixel_ch0,
    input  logic [PIX_W-1:0]  i_pixel_ch1,
    input  logic [PIX_W-1:0]  i_pixel_ch2,
    input  logic [PIX_W-1:0]  i_pixel_ch3,
    input  logic [9:0]        i_entry_index,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [PIX_W-1:0]  i_cfg_data,
    output logic              o_done,
    output logic [2:0]        o_status,
    output logic [CTR_W-1:0]  o_center_ch0,
    output logic [CTR_W-1:0]  o_center_ch1,
    output logic [CTR_W-1:0]  o_center_ch2,
    output logic [CTR_W-1:0]  o_center_ch3,
    output logic [CNT_W-1:0]  o_bin_count,
    output logic              o_entry_valid,
    output logic [10:0]       o_used_entries
);

    logic [NCH*PIX_W-1:0] r_bins;
    logic [PIX_W-1:0]     r_null;
    logic                 q_full, q_empty, push, pop, f_busy;
    t_cmd                 f_cmd, q_cmd;
    logic [NCH*CTR_W-1:0] centers;

    assign busy = f_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins <= {NCH{PIX_W'(1)}};
            r_null <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_NULL) r_null <= i_cfg_data;
            else if (i_cfg_index < CFG_NULL) r_bins[i_cfg_index[1:0]*PIX_W +: PIX_W] <= i_cfg_data;
        end
    end

    smh_front #(.CHANNELS(CHANNELS)) u_front (
        .i_clk, .i_rst_n, .i_start, .i_req_type,
        .i_pixels({i_pixel_ch3, i_pixel_ch2, i_pixel_ch1, i_pixel_ch0}),
        .i_entry_index, .i_bins(r_bins), .i_null_value(r_null),
        .i_q_full(q_full), .o_busy(f_busy), .o_push(push), .o_cmd(f_cmd)
    );

    smh_queue u_queue (
        .i_clk, .i_rst_n, .i_push(push), .i_cmd(f_cmd), .i_pop(pop),
        .o_full(q_full), .o_empty(q_empty), .o_cmd(q_cmd)
    );

    smh_back #(.CHANNELS(CHANNELS), .TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk, .i_rst_n, .i_empty(q_empty), .i_cmd(q_cmd), .i_bins(r_bins),
        .o_pop(pop), .o_valid(o_done), .o_status,
        .o_centers(centers), .o_bin_count, .o_entry_valid, .o_used_entries
    );

    assign o_center_ch0 = centers[0*CTR_W +: CTR_W];
    assign o_center_ch1 = centers[1*CTR_W +: CTR_W];
    assign o_center_ch2 = centers[2*CTR_W +: CTR_W];
    assign o_center_ch3 = centers[3*CTR_W +: CTR_W];

endmodule

[tb/testbench.sv]
module testbench;
    import smh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH       = 1024;
    localparam int unsigned QUIET_LIMIT = 20000;
    localparam logic [2:0]  CFG_BIN0    = 3'd0;
    localparam logic [2:0]  CFG_BIN1    = 3'd1;
    localparam logic [2:0]  CFG_BIN2    = 3'd2;
    localparam logic [2:0]  CFG_BIN3    = 3'd3;

    typedef struct {
        t_status     status;
        logic [16:0] center[4];
        logic [31:0] count;
        logic        valid;
        logic [10:0] used;
    } t_hist_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic              busy;
    logic [1:0]        i_req_type = REQ_NONE;
    logic [PIX_W-1:0]  i_pixel_ch0 = '0;
    logic [PIX_W-1:0]  i_pixel_ch1 = '0;
    logic [PIX_W-1:0]  i_pixel_ch2 = '0;
    logic [PIX_W-1:0]  i_pixel_ch3 = '0;
    logic [9:0]        i_entry_index = '0;
    logic              i_cfg_we = 1'b0;
    logic [2:0]        i_cfg_index = '0;
    logic [PIX_W-1:0]  i_cfg_data = '0;
    logic              o_done;
    logic [2:0]        o_status;
    logic [CTR_W-1:0]  o_center_ch0;
    logic [CTR_W-1:0]  o_center_ch1;
    logic [CTR_W-1:0]  o_center_ch2;
    logic [CTR_W-1:0]  o_center_ch3;
    logic [CNT_W-1:0]  o_bin_count;
    logic              o_entry_valid;
    logic [10:0]       o_used_entries;

    // Predictor state: a mirror of the bin table and the registers.
    logic [63:0]  bin_keys[DEPTH];
    logic [31:0]  bin_counts[DEPTH];
    int unsigned  bins_used = 0;
    logic [15:0]  bin_width[4] = '{16'd1, 16'd1, 16'd1, 16'd1};
    logic [15:0]  null_pixel = '0;

    t_hist_result pending_results[$];
    int unsigned  error_count = 0;
    int unsigned  quiet_cycles = 0;
    int unsigned  sender_idle_pct = 0;

    sparse_multichannel_histogram #(.CHANNELS(2), .TABLE_DEPTH(DEPTH)) uut (.*);

    always #1 i_clk = ~i_clk;

    function automatic logic [15:0] width_of(int ch);
        return (bin_width[ch] == 16'd0) ? 16'd1 : bin_width[ch];
    endfunction

    function automatic void fill_centers(logic [63:0] key, ref t_hist_result r);
        logic [31:0] b;
        logic [31:0] c;
        for (int ch = 0; ch < 4; ch++) begin
            r.center[ch] = '0;
            if (ch < 2) begin
                b = width_of(ch);
                c = key[16*ch +: 16] * b + (b >> 1);
                r.center[ch] = c[16:0];
            end
        end
    endfunction

    // Updates the table mirror for one accepted request and queues its result.
    function automatic void histogram_predict(t_req req, logic [15:0] px[4],
                                              logic [9:0] index);
        t_hist_result r;
        logic [63:0]  key;
        logic         is_null;
        int           hit;
        key = '0;
        is_null = 1'b0;
        hit = -1;
        if (req == REQ_NONE)
            return;
        r.status = ST_CLEARED;
        r.count = '0;
        r.valid = 1'b0;
        for (int ch = 0; ch < 4; ch++)
            r.center[ch] = '0;
        case (req)
            REQ_CLEAR: begin
                bins_used = 0;
            end
            REQ_READ: begin
                r.status = ST_READ;
                if (index < bins_used) begin
                    fill_centers(bin_keys[index], r);
                    r.count = bin_counts[index];
                    r.valid = 1'b1;
                end
            end
            default: begin
                for (int ch = 0; ch < 2; ch++) begin
                    if (px[ch] == null_pixel)
                        is_null = 1'b1;
                    key[16*ch +: 16] = px[ch] / width_of(ch);
                end
                if (is_null) begin
                    r.status = ST_NULL;
                end else begin
                    for (int i = 0; i < bins_used; i++) begin
                        if (hit < 0 && bin_keys[i] == key)
                            hit = i;
                    end
                    fill_centers(key, r);
                    if (hit >= 0) begin
                        if (bin_counts[hit] != 32'hFFFF_FFFF)
                            bin_counts[hit]++;
                        r.status = ST_COUNTED;
                        r.count = bin_counts[hit];
                        r.valid = 1'b1;
                    end else if (bins_used < DEPTH) begin
                        bin_keys[bins_used] = key;
                        bin_counts[bins_used] = 32'd1;
                        bins_used++;
                        r.status = ST_NEW;
                        r.count = 32'd1;
                        r.valid = 1'b1;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
            end
        endcase
        r.used = bins_used[10:0];
        pending_results.push_back(r);
    endfunction

    function automatic void compare_field(string name, logic [31:0] exp_v,
                                          logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $realtime, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_hist_result e;
        if (o_done) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result without a request, expected none, actual status %0h",
                         $realtime, o_status);
                error_count++;
            end else begin
                e = pending_results.pop_front();
                compare_field("status", e.status, o_status);
                compare_field("center_ch0", e.center[0], o_center_ch0);
                compare_field("center_ch1", e.center[1], o_center_ch1);
                compare_field("center_ch2", e.center[2], o_center_ch2);
                compare_field("center_ch3", e.center[3], o_center_ch3);
                compare_field("bin_count", e.count, o_bin_count);
                compare_field("entry_valid", e.valid, o_entry_valid);
                compare_field("used_entries", e.used, o_used_entries);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_start && !busy) || o_done || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Entered and left at a falling edge.
    task automatic send_request(t_req req, logic [15:0] p0, logic [15:0] p1,
                                logic [15:0] p2, logic [15:0] p3, logic [9:0] index);
        logic [15:0] px[4];
        px = '{p0, p1, p2, p3};
        i_req_type = req;
        i_pixel_ch0 = p0;
        i_pixel_ch1 = p1;
        i_pixel_ch2 = p2;
        i_pixel_ch3 = p3;
        i_entry_index = index;
        i_start = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy)
                break;
        end
        histogram_predict(req, px, index);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < sender_idle_pct) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
    endtask

    // Waits for every result, then for a request with no result still in flight.
    task automatic wait_idle();
        i_start = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);
        repeat (40 + bins_used) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [15:0] value);
        i_cfg_we = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (index == CFG_NULL)
            null_pixel = value;
        else
            bin_width[index] = value;
    endtask

    task automatic set_config(logic [15:0] b0, logic [15:0] b1, logic [15:0] b2,
                              logic [15:0] b3, logic [15:0] nul);
        wait_idle();
        write_reg(CFG_BIN0, b0);
        write_reg(CFG_BIN1, b1);
        write_reg(CFG_BIN2, b2);
        write_reg(CFG_BIN3, b3);
        write_reg(CFG_NULL, nul);
    endtask

    task automatic test_directed();
        // Reset values: null pixel is zero, all bins one wide.
        send_request(REQ_SAMPLE, 16'd0, 16'd5, 16'd0, 16'd0, 10'd0);
        send_request(REQ_SAMPLE, 16'd5, 16'd7, 16'hFFFF, 16'hFFFF, 10'd0);
        send_request(REQ_SAMPLE, 16'd5, 16'd7, 16'd0, 16'd0, 10'd0);
        send_request(REQ_SAMPLE, 16'hFFFF, 16'hFFFF, 16'h1234, 16'h8000, 10'h3FF);
        send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0);
        send_request(REQ_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'd1);
        send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 10'd2);
        send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 10'h3FF);
        send_request(REQ_NONE, 16'd9, 16'd9, 16'd9, 16'd9, 10'd0);
        send_request(REQ_CLEAR, 16'd3, 16'd3, 16'd0, 16'd0, 10'd5);
        send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0);
        // A zero bin size acts as one; widest bins and the top null value.
        set_config(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        send_request(REQ_SAMPLE, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0);
        send_request(REQ_SAMPLE, 16'd10, 16'hFFFE, 16'd0, 16'd0, 10'd0);
        send_request(REQ_SAMPLE, 16'd10, 16'd1, 16'd7, 16'd7, 10'd0);
        send_request(REQ_SAMPLE, 16'hFFFF, 16'd1, 16'd0, 16'd0, 10'd0);
        send_request(REQ_SAMPLE, 16'd3, 16'hFFFF, 16'd0, 16'd0, 10'd0);
        send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0);
        send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 10'd1);
        send_request(REQ_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0);
    endtask

    function automatic logic [15:0] pick_pixel();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, 48);
        return $urandom_range(0, 16'hFFFF);
    endfunction

    task automatic test_random(int unsigned count, int unsigned idle_pct);
        int unsigned roll;
        sender_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                if ($urandom_range(0, 3) == 0)
                    set_config($urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                               $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                               $urandom_range(0, 16'hFFFF));
                else
                    set_config($urandom_range(0, 8), $urandom_range(0, 8),
                               $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                               $urandom_range(0, 48));
            end
            roll = $urandom_range(0, 99);
            if (roll < 75)
                send_request(REQ_SAMPLE, pick_pixel(), pick_pixel(),
                             $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                             $urandom_range(0, 10'h3FF));
            else if (roll < 93)
                send_request(REQ_READ, $urandom_range(0, 16'hFFFF),
                             $urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF),
                             $urandom_range(0, 16'hFFFF),
                             (roll < 88) ? $urandom_range(0, bins_used + 2)
                                         : $urandom_range(0, 10'h3FF));
            else if (roll < 97)
                send_request(REQ_CLEAR, $urandom_range(0, 16'hFFFF), 16'd0, 16'd0,
                             16'd0, $urandom_range(0, 10'h3FF));
            else
                send_request(REQ_NONE, pick_pixel(), pick_pixel(), 16'd0, 16'd0,
                             $urandom_range(0, 10'h3FF));
        end
    endtask

    // Fills every table entry, then checks drops, hits and reads at the top.
    task automatic test_full_table();
        sender_idle_pct = 0;
        set_config(16'd1, 16'd1, 16'd1, 16'd1, 16'hFFFF);
        send_request(REQ_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0);
        for (int i = 0; i < DEPTH; i++)
            send_request(REQ_SAMPLE, i[15:0], 16'd2, 16'd0, 16'd0, 10'd0);
        send_request(REQ_SAMPLE, 16'd5, 16'd3, 16'd0, 16'd0, 10'd0);
        send_request(REQ_SAMPLE, 16'hFFFE, 16'hFFFE, 16'd0, 16'd0, 10'd0);
        send_request(REQ_SAMPLE, 16'd1023, 16'd2, 16'd0, 16'd0, 10'd0);
        send_request(REQ_SAMPLE, 16'hFFFF, 16'd2, 16'd0, 16'd0, 10'd0);
        send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 10'h3FF);
        send_request(REQ_READ, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0);
        send_request(REQ_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0);
    endtask

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_directed();
        test_random(270, 7);
        test_random(270, 87);
        test_random(270, 0);
        test_full_table();
        wait_idle();
        if (error_count == 0 && pending_results.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

[sparse_multichannel_histogram.f]
hw/rtl/smh_pkg.sv
hw/rtl/smh_front.sv
hw/rtl/smh_queue.sv
hw/rtl/smh_back.sv
hw/rtl/sparse_multichannel_histogram.sv
tb/testbench.sv
